/* sv/jtac_pkg.sv */
// ----------------------------------------------------------------------------
// jtac_pkg: shared types and constants for the Jacobian-transpose controller
// Fixed-point format, register indexes and reset values, sequencer step codes.
// ----------------------------------------------------------------------------
`default_nettype none

package jtac_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MAX_JOINTS = 8;

   localparam int DATA_W      = 32;
   localparam int CFG_W       = 31;
   localparam int ACC_W       = 35;
   localparam int ELEM_N      = 6;
   localparam int ELEM_IDX_W  = 3;
   localparam int JOINT_W     = 3;
   localparam int JOINT_CMP_W = 5;
   localparam int STEP_W      = 4;
   localparam int CSR_ADDR_W  = 3;

   // request tdata layout
   localparam int DIST_LSB    = ELEM_N * DATA_W;
   localparam int JOINT_LSB   = DIST_LSB + DATA_W;
   localparam int REQ_TDATA_W = 232;
   localparam int RSP_TDATA_W = 40;

   localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_LIN  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_ANG  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_LIN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_ANG = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_VLIMIT    = 3'd4;

   localparam logic [CFG_W-1:0]  RST_GAIN      = CFG_W'(25 << FRAC_BITS);
   localparam logic [CFG_W-1:0]  RST_RANGE_LIN = CFG_W'(((2 << FRAC_BITS) + 5) / 10);
   localparam logic [CFG_W-1:0]  RST_RANGE_ANG = CFG_W'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic [DATA_W-1:0] RST_VLIMIT    = DATA_W'(1 << (FRAC_BITS - 1));

   // request kinds
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_COLUMN = 1'b1;

   // sequencer steps of an error update; a column uses steps 0..5 for rows 0..5
   localparam logic [STEP_W-1:0] STEP_RG_LIN = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RG_ANG = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ANG_X  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_ANG_Z  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LIN_X  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_LIN_Z  = 4'd8;
   localparam logic [STEP_W-1:0] UPD_STEPS   = 4'd9;
   localparam logic [STEP_W-1:0] COL_STEPS   = 4'd6;

   typedef struct packed {
      logic              issue;
      logic [STEP_W-1:0] issue_step;
      logic              wb;
      logic [STEP_W-1:0] wb_step;
      logic              fin;
   } seq_ctrl_type;

   // element of the item touched by a step
   function automatic logic [ELEM_IDX_W-1:0] elem_of(input logic func,
                                                     input logic [STEP_W-1:0] step);
      logic [ELEM_IDX_W-1:0] idx;
      idx = '0;
      if (func == FUNC_COLUMN) begin
         if (step < COL_STEPS) idx = step[ELEM_IDX_W-1:0];
      end else if (step >= STEP_LIN_X && step <= STEP_LIN_Z) begin
         idx = ELEM_IDX_W'(step - STEP_LIN_X);
      end else if (step >= STEP_ANG_X && step <= STEP_ANG_Z) begin
         idx = step[ELEM_IDX_W-1:0];
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

/* sv/jacobian_transpose_attract_ctrl.sv */
// ----------------------------------------------------------------------------
// jacobian_transpose_attract_ctrl: attractive-field joint velocity controller
// Keeps a six-element force and maps Jacobian columns to joint velocities.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): tuser selects the kind. An error update (tuser 0)
//   carries the unit direction, angle errors and distance and rebuilds the
//   stored force; it gives no result. A Jacobian column (tuser 1) gives one
//   result: the column dotted with the force, clamped above at the limit.
//   tlast on a column comes back as tlast on its result.
//   Result channel (rsp_*): joint index and velocity in tdata.
//   Configuration (csr_*): one register per write. The user must write it
//   only while idle; the block itself does not enforce this.
// Timing: a single multiplier is shared under a step sequencer, one product
//   a cycle, each written back in the cycle after its issue. A new request
//   is taken only once the sequencer is idle again, so requests never overlap.
// Reset clears the force to zero and loads the default gains, ranges and
//   limit. A stalled result holds in the output register; a finished column
//   waits in the sequencer only while an older result is still not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobian_transpose_attract_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // elem_0..elem_5 [191:0], dist_err [223:192], joint_index [226:224]
   input  wire logic [jtac_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire logic                                  req_tuser,   // func
   input  wire logic                                  req_tlast,   // last_column
   // result
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // joint_id [2:0], joint_velocity [34:3]
   output logic [jtac_pkg::RSP_TDATA_W-1:0]           rsp_tdata,
   output logic                                       rsp_tlast,   // last_joint
   // configuration
   input  wire logic                                  csr_we,
   input  wire logic [jtac_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [jtac_pkg::DATA_W-1:0]           csr_wdata
);
   import jtac_pkg::*;

   // configuration registers
   logic [CFG_W-1:0]         gain_lin_ff, gain_ang_ff, range_lin_ff, range_ang_ff;
   logic signed [DATA_W-1:0] vlimit_ff;

   // captured request
   logic                     func_ff;
   logic signed [DATA_W-1:0] elem_ff [ELEM_N];
   logic signed [DATA_W-1:0] dist_ff;
   logic [JOINT_W-1:0]       joint_ff;
   logic                     last_ff;

   // intermediates and state
   logic signed [DATA_W-1:0] lin_sat_ff, ang_sat_ff, lin_scale_ff;
   logic signed [DATA_W-1:0] force_ff [ELEM_N];
   logic signed [ACC_W-1:0]  acc_ff;

   // result register
   logic                     rsp_valid_ff;
   logic [JOINT_W-1:0]       rsp_joint_ff;
   logic signed [DATA_W-1:0] rsp_vel_ff;
   logic                     rsp_last_ff;

   logic                     req_accept, joint_ok, start, idle, out_busy;
   seq_ctrl_type             ctrl;
   logic signed [DATA_W-1:0] op_a, op_b, mul_res;
   logic [ELEM_IDX_W-1:0]    rd_idx, wb_idx;
   logic signed [DATA_W-1:0] elem_rd, elem_wb;
   logic signed [DATA_W-1:0] range_lin_s, range_ang_s;
   logic                     below_lin, acc_in_range;
   logic signed [DATA_W-1:0] vel_sat, vel_out;

   assign req_tready = idle;
   assign req_accept = req_tvalid && req_tready;
   // drop a column whose joint is out of range
   assign joint_ok   = JOINT_CMP_W'(req_tdata[JOINT_LSB +: JOINT_W]) <
                       JOINT_CMP_W'(MAX_JOINTS);
   assign start      = req_accept && ((req_tuser == FUNC_UPDATE) || joint_ok);
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   jtac_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item_func (func_ff),
      .out_busy  (out_busy),
      .idle      (idle),
      .ctrl      (ctrl)
   );

   jtac_fxmul u_mul (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mul_res)
   );

   assign range_lin_s = $signed({1'b0, range_lin_ff});
   assign range_ang_s = $signed({1'b0, range_ang_ff});
   assign below_lin   = dist_ff < range_lin_s;

   // operand select for the issuing step
   assign rd_idx  = elem_of(func_ff, ctrl.issue_step);
   assign elem_rd = elem_ff[rd_idx];

   always_comb begin
      op_a = '0;
      op_b = '0;
      if (!ctrl.issue) begin
         // hold the multiplier inputs at zero between steps
      end else if (func_ff == FUNC_COLUMN) begin
         op_a = elem_rd;
         op_b = force_ff[rd_idx];
      end else begin
         case (ctrl.issue_step) inside
            STEP_RG_LIN: begin
               op_a = range_lin_s;
               op_b = $signed({1'b0, gain_lin_ff});
            end
            STEP_RG_ANG: begin
               op_a = range_ang_s;
               op_b = $signed({1'b0, gain_ang_ff});
            end
            STEP_SCALE: begin
               op_a = $signed({1'b0, gain_lin_ff});
               op_b = dist_ff;
            end
            [STEP_ANG_X:STEP_ANG_Z]: begin
               op_a = $signed({1'b0, gain_ang_ff});
               op_b = elem_rd;
            end
            [STEP_LIN_X:STEP_LIN_Z]: begin
               op_a = below_lin ? lin_scale_ff : lin_sat_ff;
               op_b = elem_rd;
            end
            default: begin
               op_a = '0;
               op_b = '0;
            end
         endcase
      end
   end

   assign wb_idx  = elem_of(func_ff, ctrl.wb_step);
   assign elem_wb = elem_ff[wb_idx];

   // saturate the column sum, then clamp from above only
   assign acc_in_range = (acc_ff[ACC_W-1:DATA_W-1] == '0) ||
                         (acc_ff[ACC_W-1:DATA_W-1] == '1);
   always_comb begin
      if (acc_in_range) vel_sat = acc_ff[DATA_W-1:0];
      else if (acc_ff[ACC_W-1]) vel_sat = INT_MIN;
      else vel_sat = INT_MAX;
      vel_out = (vel_sat > vlimit_ff) ? vlimit_ff : vel_sat;
   end

   // control state: configuration, force, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_lin_ff  <= RST_GAIN;
         gain_ang_ff  <= RST_GAIN;
         range_lin_ff <= RST_RANGE_LIN;
         range_ang_ff <= RST_RANGE_ANG;
         vlimit_ff    <= RST_VLIMIT;
         for (int i = 0; i < ELEM_N; i++) force_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_GAIN_LIN:  gain_lin_ff  <= csr_wdata[CFG_W-1:0];
               CSR_GAIN_ANG:  gain_ang_ff  <= csr_wdata[CFG_W-1:0];
               CSR_RANGE_LIN: range_lin_ff <= csr_wdata[CFG_W-1:0];
               CSR_RANGE_ANG: range_ang_ff <= csr_wdata[CFG_W-1:0];
               CSR_VLIMIT:    vlimit_ff    <= csr_wdata;
               default: ;     // drop writes beyond the register list
            endcase
         end
         if (ctrl.wb && func_ff == FUNC_UPDATE) begin
            case (ctrl.wb_step) inside
               [STEP_ANG_X:STEP_ANG_Z]: begin
                  // at or beyond range: saturated magnitude; zero only for zero error
                  if (elem_wb < range_ang_s) force_ff[wb_idx] <= mul_res;
                  else if (elem_wb == '0) force_ff[wb_idx] <= '0;
                  else force_ff[wb_idx] <= ang_sat_ff;
               end
               [STEP_LIN_X:STEP_LIN_Z]: force_ff[wb_idx] <= mul_res;
               default: ;
            endcase
         end
         if (ctrl.fin) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload: captured request, intermediates, accumulator, result data
   always_ff @(posedge clock) begin
      if (start) begin
         func_ff  <= req_tuser;
         for (int i = 0; i < ELEM_N; i++) elem_ff[i] <= req_tdata[i*DATA_W +: DATA_W];
         dist_ff  <= req_tdata[DIST_LSB +: DATA_W];
         joint_ff <= req_tdata[JOINT_LSB +: JOINT_W];
         last_ff  <= req_tlast;
         acc_ff   <= '0;
      end
      if (ctrl.wb) begin
         if (func_ff == FUNC_COLUMN) begin
            acc_ff <= acc_ff + ACC_W'(mul_res);
         end else begin
            case (ctrl.wb_step) inside
               STEP_RG_LIN: begin
                  // apply the sign of the distance; sign of zero is zero
                  if (dist_ff > 0) lin_sat_ff <= mul_res;
                  else if (dist_ff < 0) lin_sat_ff <= -mul_res;
                  else lin_sat_ff <= '0;
               end
               STEP_RG_ANG: ang_sat_ff   <= mul_res;
               STEP_SCALE:  lin_scale_ff <= mul_res;
               default: ;
            endcase
         end
      end
      if (ctrl.fin) begin
         rsp_joint_ff <= joint_ff;
         rsp_vel_ff   <= vel_out;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DATA_W-JOINT_W){1'b0}}, rsp_vel_ff, rsp_joint_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* sv/jtac_fxmul.sv */
// ----------------------------------------------------------------------------
// jtac_fxmul: shared fixed-point multiplier
// Registers the exact product; floors it by the fraction bits and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module jtac_fxmul (
   input  wire logic                               clock,
   input  wire logic signed [jtac_pkg::DATA_W-1:0] op_a,
   input  wire logic signed [jtac_pkg::DATA_W-1:0] op_b,
   output logic      signed [jtac_pkg::DATA_W-1:0] result
);
   import jtac_pkg::*;

   localparam int PROD_W = 2 * DATA_W;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] shifted;
   logic                     in_range;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift floors toward minus infinity
   assign shifted  = prod_ff >>> FRAC_BITS;
   assign in_range = (shifted[PROD_W-1:DATA_W-1] == '0) ||
                     (shifted[PROD_W-1:DATA_W-1] == '1);

   always_comb begin
      if (in_range) result = shifted[DATA_W-1:0];
      else if (shifted[PROD_W-1]) result = INT_MIN;
      else result = INT_MAX;
   end

endmodule

`default_nettype wire

/* sv/jtac_seq.sv */
// ----------------------------------------------------------------------------
// jtac_seq: step sequencer
// Issues a multiply a cycle, writes it back next cycle; columns then finish.
// ----------------------------------------------------------------------------
`default_nettype none

module jtac_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   item_func,
   input  wire logic                   out_busy,
   output logic                        idle,
   output jtac_pkg::seq_ctrl_type      ctrl
);
   import jtac_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [STEP_W-1:0] n_steps;

   assign n_steps = (item_func == FUNC_COLUMN) ? COL_STEPS : UPD_STEPS;
   assign idle    = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            ctrl.issue      = (cnt_ff < n_steps);
            ctrl.issue_step = cnt_ff;
            ctrl.wb         = (cnt_ff != '0);
            ctrl.wb_step    = cnt_ff - STEP_W'(1);
            if (cnt_ff == n_steps) begin
               state_in = (item_func == FUNC_COLUMN) ? ST_FIN : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_FIN: begin
            ctrl.fin = !out_busy;
            if (!out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* sv/jtac_checker.sv */
// ----------------------------------------------------------------------------
// jtac_checker: port-level checks for the Jacobian-transpose controller
// Watches the request and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module jtac_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [jtac_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input wire logic                               req_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [jtac_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import jtac_pkg::*;

   logic req_fire, joint_ok;

   assign req_fire = req_tvalid && req_tready;
   assign joint_ok = JOINT_CMP_W'(req_tdata[JOINT_LSB +: JOINT_W]) <
                     JOINT_CMP_W'(MAX_JOINTS);

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire && ((req_tuser == FUNC_UPDATE) || joint_ok) |=> !req_tready)
      else $error("request taken while previous request still in work");

   a_update_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == FUNC_UPDATE) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("error update produced a result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

endmodule

bind jacobian_transpose_attract_ctrl jtac_checker u_checker (.*);

`default_nettype wire

/* sim/tb_jacobian_transpose_attract_ctrl.sv */
// ----------------------------------------------------------------------------
// tb_jacobian_transpose_attract_ctrl: self-checking regression of the controller
// Drives error updates and Jacobian columns over the request stream. A
// scoreboard predicts every joint velocity in Q16.16 and checks it against the
// result stream under random idling on both sides and a long result stall.
// ----------------------------------------------------------------------------

module tb_jacobian_transpose_attract_ctrl;

   import jtac_pkg::*;

   localparam int     DRAIN_CYCLES = 20;        // covers an update still in work
   localparam int     DRAIN_LIMIT  = 20000;
   localparam int     REPORT_MAX   = 10;
   localparam int     STALL_CYCLES = 400;
   localparam int     SEGMENT_REQS = 180;
   localparam int     Q_ONE        = 1 << FRAC_BITS;
   localparam longint Q_MAX        = 2147483647;
   localparam longint Q_MIN        = -Q_MAX - 1;

   typedef struct packed {
      logic                          func;
      logic [ELEM_N-1:0][DATA_W-1:0] elem;
      logic [DATA_W-1:0]             dist_err;
      logic [JOINT_W-1:0]            joint;
      logic                          last;
   } attract_req_type;

   typedef struct packed {
      logic [JOINT_W-1:0] joint;
      logic [DATA_W-1:0]  vel;
      logic               last;
   } joint_vel_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [DATA_W-1:0]      csr_wdata  = '0;

   jacobian_transpose_attract_ctrl i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the block: registers and stored force
   longint gain_lin, gain_ang, range_lin, range_ang, vel_limit;
   longint attract_force [ELEM_N];
   joint_vel_type vel_expected [$];

   int error_count   = 0;
   int n_updates     = 0;
   int n_columns     = 0;
   int n_checked     = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int rsp_stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for the block");
      $display("jacobian_transpose_attract_ctrl regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- Q16.16 math
   function automatic longint q_sat(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // exact product, floor shift, saturate
   function automatic longint q_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return q_sat(p >>> FRAC_BITS);
   endfunction

   function automatic longint q_sign(input longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   function automatic longint sx32(input logic [DATA_W-1:0] v);
      return longint'($signed(v));
   endfunction

   task automatic reset_shadow();
      gain_lin  = longint'(RST_GAIN);
      gain_ang  = longint'(RST_GAIN);
      range_lin = longint'(RST_RANGE_LIN);
      range_ang = longint'(RST_RANGE_ANG);
      vel_limit = sx32(RST_VLIMIT);
      for (int i = 0; i < ELEM_N; i++) attract_force[i] = 0;
   endtask

   task automatic shadow_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      case (addr)
         CSR_GAIN_LIN:  gain_lin  = longint'(data[CFG_W-1:0]);
         CSR_GAIN_ANG:  gain_ang  = longint'(data[CFG_W-1:0]);
         CSR_RANGE_LIN: range_lin = longint'(data[CFG_W-1:0]);
         CSR_RANGE_ANG: range_ang = longint'(data[CFG_W-1:0]);
         CSR_VLIMIT:    vel_limit = sx32(data);
         default: ;     // unused index: drop
      endcase
   endtask

   // rebuild the force on an update, queue a velocity for a column
   task automatic predict_velocity(input attract_req_type it);
      longint        e [ELEM_N];
      longint        d, lin_sat, ang_sat, lin_scale, acc, vel;
      joint_vel_type want;
      for (int i = 0; i < ELEM_N; i++) e[i] = sx32(it.elem[i]);
      if (it.func == FUNC_UPDATE) begin
         n_updates++;
         d         = sx32(it.dist_err);
         lin_sat   = q_mul(range_lin, gain_lin) * q_sign(d);
         ang_sat   = q_mul(range_ang, gain_ang);
         lin_scale = q_mul(gain_lin, d);
         for (int i = 0; i < 3; i++) begin
            if (d < range_lin) attract_force[i] = q_mul(lin_scale, e[i]);
            else attract_force[i] = q_mul(lin_sat, e[i]);
         end
         // only the positive side saturates; large negative errors stay linear
         for (int i = 3; i < ELEM_N; i++) begin
            if (e[i] < range_ang) attract_force[i] = q_mul(gain_ang, e[i]);
            else attract_force[i] = ang_sat * q_sign(e[i]);
         end
      end else if (int'(it.joint) < MAX_JOINTS) begin
         n_columns++;
         acc = 0;
         for (int i = 0; i < ELEM_N; i++) acc += q_mul(e[i], attract_force[i]);
         vel = q_sat(acc);
         if (vel > vel_limit) vel = vel_limit;
         want.joint = it.joint;
         want.vel   = DATA_W'(vel);
         want.last  = it.last;
         vel_expected.insert(vel_expected.size(), want);
      end
   endtask

   // ---------------------------------------------------------------- drivers
   task automatic send_request(input attract_req_type it);
      logic [REQ_TDATA_W-1:0] bus;
      bus = '0;
      bus[DIST_LSB-1:0]          = it.elem;
      bus[DIST_LSB +: DATA_W]    = it.dist_err;
      bus[JOINT_LSB +: JOINT_W]  = it.joint;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bus;
      req_tuser  <= it.func;
      req_tlast  <= it.last;
      do @(posedge clock); while (!req_tready);
      predict_velocity(it);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      shadow_csr(addr, data);
   endtask

   // stop offering, let all results drain and the last update finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (vel_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver: random idling, plus a counted hold-off when asked
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%0t mismatch: %s", $time, msg);
   endtask

   // compare each accepted result with the oldest predicted velocity
   always @(posedge clock) begin
      joint_vel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_checked++;
         if (vel_expected.size() == 0) begin
            report_error($sformatf("unexpected result joint %0d velocity %h",
                                   rsp_tdata[JOINT_W-1:0], rsp_tdata[JOINT_W +: DATA_W]));
         end else begin
            want = vel_expected.pop_front();
            if (rsp_tdata[JOINT_W-1:0] !== want.joint)
               report_error($sformatf("joint_id expected %0d actual %0d",
                                      want.joint, rsp_tdata[JOINT_W-1:0]));
            if (rsp_tdata[JOINT_W +: DATA_W] !== want.vel)
               report_error($sformatf("joint %0d velocity expected %h actual %h",
                                      want.joint, want.vel, rsp_tdata[JOINT_W +: DATA_W]));
            if (rsp_tlast !== want.last)
               report_error($sformatf("joint %0d last expected %b actual %b",
                                      want.joint, want.last, rsp_tlast));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic attract_req_type mk_req(input logic func,
                                              input logic [DATA_W-1:0] e0, e1, e2, e3, e4, e5,
                                              input logic [DATA_W-1:0] dist_err,
                                              input logic [JOINT_W-1:0] joint,
                                              input logic last);
      attract_req_type it;
      it.func     = func;
      it.elem[0]  = e0;
      it.elem[1]  = e1;
      it.elem[2]  = e2;
      it.elem[3]  = e3;
      it.elem[4]  = e4;
      it.elem[5]  = e5;
      it.dist_err = dist_err;
      it.joint    = joint;
      it.last     = last;
      return it;
   endfunction

   // mostly within +-span, sometimes zero or any 32-bit pattern
   function automatic logic [DATA_W-1:0] q_rand(input int span);
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) return $urandom;
      if (pick == 1) return '0;
      return DATA_W'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic attract_req_type rand_update();
      attract_req_type it;
      int pick;
      it.func  = FUNC_UPDATE;
      it.joint = JOINT_W'($urandom);
      it.last  = 1'($urandom);
      for (int i = 0; i < 3; i++) it.elem[i] = q_rand(Q_ONE);
      for (int i = 3; i < ELEM_N; i++) begin
         pick = $urandom_range(7);
         if (pick == 0) it.elem[i] = DATA_W'(range_ang);
         else if (pick == 1) it.elem[i] = DATA_W'(-range_ang);
         else it.elem[i] = q_rand(Q_ONE / 2);
      end
      pick = $urandom_range(7);
      if (pick == 0) it.dist_err = DATA_W'(range_lin);
      else if (pick == 1) it.dist_err = DATA_W'(range_lin - 1);
      else it.dist_err = q_rand(Q_ONE);
      return it;
   endfunction

   function automatic attract_req_type rand_column(input logic [JOINT_W-1:0] joint,
                                                   input logic last);
      attract_req_type it;
      it.func     = FUNC_COLUMN;
      it.dist_err = $urandom;
      it.joint    = joint;
      it.last     = last;
      for (int i = 0; i < ELEM_N; i++) it.elem[i] = q_rand(2 * Q_ONE);
      return it;
   endfunction

   function automatic attract_req_type rand_noise();
      attract_req_type it;
      it.func     = 1'($urandom);
      it.dist_err = $urandom;
      it.joint    = JOINT_W'($urandom);
      it.last     = 1'($urandom);
      for (int i = 0; i < ELEM_N; i++) it.elem[i] = $urandom;
      return it;
   endfunction

   task automatic set_config_random(input bit full_width);
      logic [DATA_W-1:0] vlim;
      if (full_width) begin
         vlim = $urandom;
      end else if ($urandom_range(3) == 0) begin
         vlim = INT_MAX;
      end else begin
         vlim = DATA_W'(int'($urandom_range(8 * Q_ONE)) - 4 * Q_ONE);
      end
      csr_write(CSR_GAIN_LIN,  full_width ? $urandom : $urandom_range(100 * Q_ONE));
      csr_write(CSR_GAIN_ANG,  full_width ? $urandom : $urandom_range(100 * Q_ONE));
      csr_write(CSR_RANGE_LIN, full_width ? $urandom : $urandom_range(Q_ONE));
      csr_write(CSR_RANGE_ANG, full_width ? $urandom : $urandom_range(Q_ONE));
      csr_write(CSR_VLIMIT, vlim);
   endtask

   // ---------------------------------------------------------------- tests
   // columns against the reset force: velocity is min(0, limit)
   task automatic test_column_before_update();
      send_request(mk_req(FUNC_COLUMN, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX,
                          INT_MAX, 3'd0, 1'b0));
      send_request(mk_req(FUNC_COLUMN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN,
                          INT_MIN, 3'd7, 1'b1));
   endtask

   // linear and saturated force regions at the default settings
   task automatic test_force_regions();
      // below range: linear, with one large negative angle error
      send_request(mk_req(FUNC_UPDATE, 32'(Q_ONE), '0, 32'(-Q_ONE),
                          32'(Q_ONE / 20), 32'(-3 * Q_ONE), 32'(RST_RANGE_ANG),
                          32'(Q_ONE / 10), 3'd5, 1'b1));
      send_request(mk_req(FUNC_COLUMN, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE),
                          32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE), '0, 3'd1, 1'b0));
      // distance exactly at range: saturated, extreme directions and angles
      send_request(mk_req(FUNC_UPDATE, INT_MAX, INT_MIN, 32'(Q_ONE / 2),
                          INT_MAX, INT_MIN, '0, 32'(RST_RANGE_LIN), 3'd0, 1'b0));
      send_request(mk_req(FUNC_COLUMN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN,
                          '0, 3'd2, 1'b0));
      send_request(mk_req(FUNC_COLUMN, 32'(Q_ONE / 4), 32'(-Q_ONE / 4), 32'(Q_ONE),
                          32'(Q_ONE / 8), 32'(-Q_ONE), 32'(Q_ONE), '0, 3'd3, 1'b1));
      // zero distance: sign of zero, angles just below and around range
      send_request(mk_req(FUNC_UPDATE, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE),
                          32'(RST_RANGE_ANG - 1), 32'(-int'(RST_RANGE_ANG)), 32'(Q_ONE),
                          '0, 3'd7, 1'b0));
      send_request(mk_req(FUNC_COLUMN, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE),
                          32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE), '0, 3'd4, 1'b0));
      // most negative distance: linear, saturates through the products
      send_request(mk_req(FUNC_UPDATE, INT_MAX, INT_MIN, INT_MAX,
                          32'(-Q_ONE), 32'(Q_ONE / 3), INT_MAX, INT_MIN, 3'd2, 1'b1));
      send_request(mk_req(FUNC_COLUMN, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX,
                          '0, 3'd5, 1'b0));
      send_request(mk_req(FUNC_COLUMN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN,
                          '0, 3'd6, 1'b1));
      // largest distance: saturated positive sign
      send_request(mk_req(FUNC_UPDATE, 32'(-Q_ONE), 32'(Q_ONE / 2), '0,
                          32'(Q_ONE), '0, INT_MIN, INT_MAX, 3'd4, 1'b0));
      send_request(mk_req(FUNC_COLUMN, 32'(Q_ONE), INT_MIN, INT_MAX, 32'(-Q_ONE), '0,
                          32'(Q_ONE), '0, 3'd7, 1'b1));
   endtask

   // register extremes, masked upper bit, unused indexes
   task automatic test_csr_settings();
      settle_block();
      // zero ranges with zero errors give zero force
      csr_write(CSR_RANGE_LIN, '0);
      csr_write(CSR_RANGE_ANG, '0);
      send_request(mk_req(FUNC_UPDATE, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE),
                          '0, '0, 32'(Q_ONE / 2), '0, 3'd0, 1'b0));
      send_request(mk_req(FUNC_COLUMN, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX,
                          '0, 3'd0, 1'b1));
      settle_block();
      // largest gains and ranges, lowest possible limit
      csr_write(CSR_GAIN_LIN,  32'hFFFF_FFFF);
      csr_write(CSR_GAIN_ANG,  32'h7FFF_FFFF);
      csr_write(CSR_RANGE_LIN, 32'h7FFF_FFFF);
      csr_write(CSR_RANGE_ANG, 32'hFFFF_FFFF);
      csr_write(CSR_VLIMIT, INT_MIN);
      send_request(mk_req(FUNC_UPDATE, 32'(Q_ONE), 32'(-Q_ONE), INT_MAX,
                          INT_MAX, INT_MIN, 32'(Q_ONE), INT_MAX, 3'd1, 1'b0));
      send_request(mk_req(FUNC_COLUMN, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE),
                          32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE), '0, 3'd1, 1'b1));
      settle_block();
      csr_write(CSR_VLIMIT, INT_MAX);
      send_request(mk_req(FUNC_COLUMN, 32'(Q_ONE), INT_MIN, 32'(Q_ONE),
                          32'(-Q_ONE), INT_MAX, 32'(Q_ONE), '0, 3'd2, 1'b1));
      settle_block();
      // writes past the register list must leave every setting alone
      for (int a = int'(CSR_VLIMIT) + 1; a < (1 << CSR_ADDR_W); a++)
         csr_write(CSR_ADDR_W'(a), $urandom);
      send_request(mk_req(FUNC_COLUMN, 32'(Q_ONE), INT_MIN, 32'(Q_ONE),
                          32'(-Q_ONE), INT_MAX, 32'(Q_ONE), '0, 3'd3, 1'b1));
      settle_block();
      csr_write(CSR_GAIN_LIN,  32'(RST_GAIN));
      csr_write(CSR_GAIN_ANG,  32'(RST_GAIN));
      csr_write(CSR_RANGE_LIN, 32'(RST_RANGE_LIN));
      csr_write(CSR_RANGE_ANG, 32'(RST_RANGE_ANG));
      csr_write(CSR_VLIMIT,    RST_VLIMIT);
   endtask

   // hold the receiver off while columns keep coming: the block must stall
   task automatic test_stalled_results();
      int saved_pct;
      settle_block();
      saved_pct      = req_idle_pct;
      req_idle_pct   = 0;
      rsp_stall_left = STALL_CYCLES;
      send_request(rand_update());
      for (int j = 0; j < 24; j++)
         send_request(rand_column(JOINT_W'(j), (j % MAX_JOINTS) == MAX_JOINTS - 1));
      req_idle_pct = saved_pct;
   endtask

   // mostly an update then a run of columns ending in last; some noise
   task automatic test_random_traffic(input int n_reqs);
      int sent;
      int cols;
      sent = 0;
      while (sent < n_reqs) begin
         if ($urandom_range(9) == 0) begin
            send_request(rand_noise());
            sent++;
         end else begin
            send_request(rand_update());
            sent++;
            cols = $urandom_range(1, MAX_JOINTS);
            for (int j = 0; j < cols; j++) begin
               send_request(rand_column(JOINT_W'(j), j == cols - 1));
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      int wait_cnt;
      reset_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 35;
      rsp_idle_pct = 54;
      test_column_before_update();
      test_force_regions();
      test_csr_settings();
      test_stalled_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 35; rsp_idle_pct = 54; end
            1: begin req_idle_pct = 54; rsp_idle_pct = 35; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         settle_block();
         set_config_random(1'b0);
         test_random_traffic(SEGMENT_REQS);
         settle_block();
         set_config_random(1'b1);
         test_random_traffic(SEGMENT_REQS);
      end

      // drain: every prediction must come back, then let the block go quiet
      req_tvalid <= 1'b0;
      wait_cnt = 0;
      while (vel_expected.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cnt++;
      end
      if (vel_expected.size() != 0) begin
         $display("%0d joint velocities never arrived", vel_expected.size());
         $display("jacobian_transpose_attract_ctrl regression: fail");
         $finish;
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         $display("covered %0d force updates and %0d Jacobian columns under three idle mixes",
                  n_updates, n_columns);
         $display("%0d joint velocities checked, %0d mismatches", n_checked, error_count);
         if (error_count == 0) begin
            $display("jacobian_transpose_attract_ctrl regression: pass");
         end else begin
            $display("jacobian_transpose_attract_ctrl regression: fail");
         end
         $finish;
      end
   end

endmodule
